@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the cycle in which ante holds
`define VCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that cons holds in the cycle after ante holds
`define VCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/core/vcc_pkg.sv @@
// Package with widths, register indexes and defaults of the volume moment block
package vcc_pkg;

	localparam int MAX_DIM_DEF = 1024;

	localparam int VOX_W  = 16;
	localparam int QTY_W  = 3;
	localparam int VAL_W  = 41;
	localparam int CNT_W  = 30;
	localparam int SUM1_W = 40;
	localparam int SUM2_W = 52;
	localparam int FRAC_W = 16;
	localparam int DVD_W  = SUM2_W + FRAC_W;
	localparam int STEP_W = $clog2(DVD_W + 1);

	localparam int APB_AW = 5;
	localparam int APB_DW = 32;
	localparam int SIZE_W = 11;
	localparam int CTR_W  = 10;

	typedef enum logic [2:0] {
		REG_MODE     = 3'd0,
		REG_X_SIZE   = 3'd1,
		REG_Y_SIZE   = 3'd2,
		REG_CENTER_X = 3'd3,
		REG_CENTER_Y = 3'd4,
		REG_CENTER_Z = 3'd5
	} reg_idx_t;

	localparam logic [QTY_W-1:0] QTY_CENTROID_LAST = 3'd2;
	localparam logic [QTY_W-1:0] QTY_COV_LAST      = 3'd5;

endpackage

@@ rtl/core/vcc_if.sv @@
// Stream interfaces for voxel transactions and result transactions
interface vcc_in_if;
	logic                       valid;
	logic                       ready;
	logic [vcc_pkg::VOX_W-1:0]  voxel_value;
	logic                       last_voxel;

	modport source (output valid, output voxel_value, output last_voxel, input ready);
	modport sink (input valid, input voxel_value, input last_voxel, output ready);
endinterface

interface vcc_out_if;
	logic                              valid;
	logic                              ready;
	logic [vcc_pkg::QTY_W-1:0]         quantity;
	logic signed [vcc_pkg::VAL_W-1:0]  moment_value;
	logic                              empty_volume;
	logic                              final_result;

	modport source (output valid, output quantity, output moment_value,
		output empty_volume, output final_result, input ready);
	modport sink (input valid, input quantity, input moment_value,
		input empty_volume, input final_result, output ready);
endinterface

@@ rtl/core/vcc_div.sv @@
// Restoring divider, one quotient bit per cycle
module vcc_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [vcc_pkg::DVD_W-1:0]   dividend,
	input  logic [vcc_pkg::CNT_W-1:0]   divisor,
	output logic                        done,
	output logic [vcc_pkg::DVD_W-1:0]   quotient
);

	localparam int DW = vcc_pkg::DVD_W;
	localparam int NW = vcc_pkg::CNT_W;

	logic                          busy_q;
	logic                          done_q;
	logic [vcc_pkg::STEP_W-1:0]    step_q;
	logic [NW:0]                   rem_q;
	logic [DW-1:0]                 quo_q;
	logic [NW:0]                   shifted;
	logic [NW+1:0]                 diff;
	logic                          bit_d;

	always_comb begin
		shifted = {rem_q[NW-1:0], quo_q[DW-1]};
		diff    = {1'b0, shifted} - {2'b00, divisor};
		bit_d   = !diff[NW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == vcc_pkg::STEP_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= bit_d ? diff[NW:0] : shifted;
			quo_q <= {quo_q[DW-2:0], bit_d};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/core/volume_centroid_and_covariance.sv @@
// Top level of the volume centroid and covariance block
//
// Voxels arrive on vox, x fastest, then y, then z; results leave on res.
// A voxel transaction is taken when vox.valid and vox.ready are high. One
// shared multiplier and one accumulator adder handle the six second-order
// products, so a nonzero voxel holds the block in ST_MUL with vox.ready low
// meanwhile; a zero voxel leaves vox.ready high unless it is the last one.
// On the voxel marked last, a restoring divider (one bit per cycle, 68
// steps) produces each result: the first is loaded after ST_FIN, ST_DIVST
// and the division, each further one after another ST_DIVST and division;
// 3 results in centroid mode, 6 in covariance mode, and 1 flagged result,
// loaded via ST_FIN and ST_EMPTY, for an empty volume.
// Results sit in an output register; while res.ready is low the block
// finishes the next quotient and then waits. New voxels are taken as soon as
// the last result of a volume is loaded, even if it is still stalled.
// Configuration goes through the APB port (register i at byte address 4*i);
// write it only while idle, which the block does not enforce. Reset clears
// counters, sums, output valid; sets x_size, y_size to 1; no clearing pass.
module volume_centroid_and_covariance #(
	parameter int MAX_DIM = vcc_pkg::MAX_DIM_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	vcc_in_if.sink                       vox,
	vcc_out_if.source                    res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [vcc_pkg::APB_AW-1:0]   paddr,
	input  logic [vcc_pkg::APB_DW-1:0]   pwdata,
	output logic [vcc_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);

	localparam int CW  = $clog2(MAX_DIM);
	localparam int DXW = ((CW > vcc_pkg::CTR_W) ? CW : vcc_pkg::CTR_W) + 1;
	localparam int SW  = ((CW + 1 > vcc_pkg::SIZE_W) ? CW + 1 : vcc_pkg::SIZE_W);
	localparam int PW  = 2 * DXW;
	localparam int S1W = vcc_pkg::SUM1_W;
	localparam int S2W = vcc_pkg::SUM2_W;
	localparam int NW  = vcc_pkg::CNT_W;
	localparam int VW  = vcc_pkg::VAL_W;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MUL   = 7'b0000010,
		ST_FIN   = 7'b0000100,
		ST_DIVST = 7'b0001000,
		ST_DIV   = 7'b0010000,
		ST_EMIT  = 7'b0100000,
		ST_EMPTY = 7'b1000000
	} state_t;

	state_t                     state_q;

	logic                       mode_q;
	logic [vcc_pkg::SIZE_W-1:0] x_size_q;
	logic [vcc_pkg::SIZE_W-1:0] y_size_q;
	logic [vcc_pkg::CTR_W-1:0]  cx_q;
	logic [vcc_pkg::CTR_W-1:0]  cy_q;
	logic [vcc_pkg::CTR_W-1:0]  cz_q;

	logic [CW-1:0]              x_cnt_q;
	logic [CW-1:0]              y_cnt_q;
	logic [CW-1:0]              z_cnt_q;
	logic [NW-1:0]              count_q;
	logic [S1W-1:0]             sum1_q [3];
	logic [S2W-1:0]             sum2_q [6];

	logic signed [DXW-1:0]      dx_q;
	logic signed [DXW-1:0]      dy_q;
	logic signed [DXW-1:0]      dz_q;
	logic                       last_q;
	logic [2:0]                 k_q;
	logic signed [PW-1:0]       prod_s1;
	logic [vcc_pkg::QTY_W-1:0]  r_q;
	logic                       neg_q;

	logic                       res_valid_q;
	logic [vcc_pkg::QTY_W-1:0]  res_qty_q;
	logic [VW-1:0]              res_val_q;
	logic                       res_empty_q;
	logic                       res_final_q;

	logic                       cfg_wr;
	logic                       vox_acc;
	logic                       vox_nz;
	logic                       slot_free;
	logic                       res_load;
	logic [SW-1:0]              xs;
	logic [SW-1:0]              ys;
	logic                       x_wrap;
	logic                       y_wrap;
	logic                       z_wrap;
	logic signed [DXW-1:0]      op_a;
	logic signed [DXW-1:0]      op_b;
	logic [2:0]                 idx;
	logic [S1W-1:0]             rd1;
	logic [S2W-1:0]             rd2;
	logic [S2W-1:0]             mag;
	logic [vcc_pkg::DVD_W-1:0]  dividend;
	logic                       div_start;
	logic                       div_done;
	logic [vcc_pkg::DVD_W-1:0]  div_quo;
	logic [VW-1:0]              quo_lo;
	logic [vcc_pkg::QTY_W-1:0]  r_last;
	logic                       is_final;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign vox.ready = (state_q == ST_IDLE);
	assign vox_acc   = vox.valid && vox.ready;
	assign vox_nz    = (vox.voxel_value != '0);
	assign slot_free = !res_valid_q || res.ready;
	assign res_load  = ((state_q == ST_EMIT) || (state_q == ST_EMPTY)) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			x_size_q <= vcc_pkg::SIZE_W'(1);
			y_size_q <= vcc_pkg::SIZE_W'(1);
			cx_q     <= '0;
			cy_q     <= '0;
			cz_q     <= '0;
		end else if (cfg_wr) begin
			case (paddr[vcc_pkg::APB_AW-1:2])
				vcc_pkg::REG_MODE:     mode_q   <= pwdata[0];
				vcc_pkg::REG_X_SIZE:   x_size_q <= pwdata[vcc_pkg::SIZE_W-1:0];
				vcc_pkg::REG_Y_SIZE:   y_size_q <= pwdata[vcc_pkg::SIZE_W-1:0];
				vcc_pkg::REG_CENTER_X: cx_q     <= pwdata[vcc_pkg::CTR_W-1:0];
				vcc_pkg::REG_CENTER_Y: cy_q     <= pwdata[vcc_pkg::CTR_W-1:0];
				vcc_pkg::REG_CENTER_Z: cz_q     <= pwdata[vcc_pkg::CTR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[vcc_pkg::APB_AW-1:2])
			vcc_pkg::REG_MODE:     prdata = vcc_pkg::APB_DW'(mode_q);
			vcc_pkg::REG_X_SIZE:   prdata = vcc_pkg::APB_DW'(x_size_q);
			vcc_pkg::REG_Y_SIZE:   prdata = vcc_pkg::APB_DW'(y_size_q);
			vcc_pkg::REG_CENTER_X: prdata = vcc_pkg::APB_DW'(cx_q);
			vcc_pkg::REG_CENTER_Y: prdata = vcc_pkg::APB_DW'(cy_q);
			vcc_pkg::REG_CENTER_Z: prdata = vcc_pkg::APB_DW'(cz_q);
			default:               prdata = '0;
		endcase
	end

	always_comb begin
		if (x_size_q == '0)
			xs = SW'(1);
		else if (SW'(x_size_q) > SW'(MAX_DIM))
			xs = SW'(MAX_DIM);
		else
			xs = SW'(x_size_q);
		if (y_size_q == '0)
			ys = SW'(1);
		else if (SW'(y_size_q) > SW'(MAX_DIM))
			ys = SW'(MAX_DIM);
		else
			ys = SW'(y_size_q);
		x_wrap = (SW'(x_cnt_q) + SW'(1)) >= xs;
		y_wrap = (SW'(y_cnt_q) + SW'(1)) >= ys;
		z_wrap = (SW'(z_cnt_q) + SW'(1)) >= SW'(MAX_DIM);
	end

	always_comb begin
		case (k_q)
			3'd0:    begin op_a = dx_q; op_b = dx_q; end
			3'd1:    begin op_a = dy_q; op_b = dy_q; end
			3'd2:    begin op_a = dz_q; op_b = dz_q; end
			3'd3:    begin op_a = dx_q; op_b = dy_q; end
			3'd4:    begin op_a = dx_q; op_b = dz_q; end
			default: begin op_a = dy_q; op_b = dz_q; end
		endcase
	end

	assign idx = (state_q == ST_MUL) ? (k_q - 3'd1) : r_q;
	assign rd1 = sum1_q[idx[1:0]];
	assign rd2 = sum2_q[idx];
	assign mag = rd2[S2W-1] ? (S2W'(0) - rd2) : rd2;

	always_comb begin
		if (mode_q)
			dividend = {mag, vcc_pkg::FRAC_W'(0)};
		else
			dividend = vcc_pkg::DVD_W'(rd1);
	end

	assign div_start = (state_q == ST_DIVST);
	assign quo_lo    = div_quo[VW-1:0];
	assign r_last    = mode_q ? vcc_pkg::QTY_COV_LAST : vcc_pkg::QTY_CENTROID_LAST;
	assign is_final  = (r_q == r_last);

	vcc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			x_cnt_q     <= '0;
			y_cnt_q     <= '0;
			z_cnt_q     <= '0;
			count_q     <= '0;
			sum1_q      <= '{default: '0};
			sum2_q      <= '{default: '0};
			k_q         <= '0;
			r_q         <= '0;
			last_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res.ready && !res_load)
				res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (vox_acc) begin
						last_q <= vox.last_voxel;
						k_q    <= '0;
						if (vox_nz) begin
							if (count_q != '1)
								count_q <= count_q + 1'b1;
							sum1_q[0] <= sum1_q[0] + S1W'(x_cnt_q);
							sum1_q[1] <= sum1_q[1] + S1W'(y_cnt_q);
							sum1_q[2] <= sum1_q[2] + S1W'(z_cnt_q);
							state_q   <= ST_MUL;
						end else if (vox.last_voxel) begin
							state_q <= ST_FIN;
						end
						if (vox.last_voxel) begin
							x_cnt_q <= '0;
							y_cnt_q <= '0;
							z_cnt_q <= '0;
						end else if (!x_wrap) begin
							x_cnt_q <= x_cnt_q + 1'b1;
						end else begin
							x_cnt_q <= '0;
							if (!y_wrap) begin
								y_cnt_q <= y_cnt_q + 1'b1;
							end else begin
								y_cnt_q <= '0;
								z_cnt_q <= z_wrap ? '0 : z_cnt_q + 1'b1;
							end
						end
					end
				end
				ST_MUL: begin
					k_q <= k_q + 3'd1;
					if (k_q != 3'd0)
						sum2_q[idx] <= rd2 + {{(S2W-PW){prod_s1[PW-1]}}, prod_s1};
					if (k_q == 3'd6)
						state_q <= last_q ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					r_q     <= '0;
					state_q <= (count_q == '0) ? ST_EMPTY : ST_DIVST;
				end
				ST_DIVST: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						if (is_final) begin
							count_q <= '0;
							sum1_q  <= '{default: '0};
							sum2_q  <= '{default: '0};
							state_q <= ST_IDLE;
						end else begin
							r_q     <= r_q + 1'b1;
							state_q <= ST_DIVST;
						end
					end
				end
				ST_EMPTY: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (vox_acc) begin
			dx_q <= DXW'(x_cnt_q) - DXW'(cx_q);
			dy_q <= DXW'(y_cnt_q) - DXW'(cy_q);
			dz_q <= DXW'(z_cnt_q) - DXW'(cz_q);
		end
		if (state_q == ST_MUL)
			prod_s1 <= op_a * op_b;
		if (state_q == ST_DIVST)
			neg_q <= mode_q && rd2[S2W-1];
		if (state_q == ST_EMIT && slot_free) begin
			res_qty_q   <= r_q;
			res_val_q   <= neg_q ? (VW'(0) - quo_lo) : quo_lo;
			res_empty_q <= 1'b0;
			res_final_q <= is_final;
		end else if (state_q == ST_EMPTY && slot_free) begin
			res_qty_q   <= '0;
			res_val_q   <= '0;
			res_empty_q <= 1'b1;
			res_final_q <= 1'b1;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.quantity     = res_qty_q;
	assign res.moment_value = res_val_q;
	assign res.empty_volume = res_empty_q;
	assign res.final_result = res_final_q;

endmodule

@@ rtl/core/vcc_checker.sv @@
// Port checker for the volume centroid and covariance block, with its bind
`include "assert_macros.svh"

module vcc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic [vcc_pkg::QTY_W-1:0]         res_quantity,
	input logic signed [vcc_pkg::VAL_W-1:0]  res_moment_value,
	input logic                              res_empty_volume,
	input logic                              res_final_result
);

	`VCC_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	`VCC_ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && !res_ready, $stable(res_moment_value) && $stable(res_quantity))
	`VCC_ASSERT_NOW(a_empty_form, clk, arst_n, res_valid && res_empty_volume, res_final_result && res_moment_value == '0 && res_quantity == '0)
	`VCC_ASSERT_NOW(a_qty_range, clk, arst_n, res_valid, res_quantity <= vcc_pkg::QTY_COV_LAST)

endmodule

bind volume_centroid_and_covariance vcc_checker u_vcc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_quantity     (res.quantity),
	.res_moment_value (res.moment_value),
	.res_empty_volume (res.empty_volume),
	.res_final_result (res.final_result)
);
